[sv/tafc_pkg.sv]
package tafc_pkg;

	// Width of the serial divider's dividend: a 32-bit difference scaled by 1024.
	localparam int DivW = 42;
	localparam int DivCntW = $clog2(DivW);
	localparam int DivisorW = 32;
	// Fraction of the fade in 1/1024 steps, 0..1024.
	localparam int FracW = 11;

	localparam logic [DivisorW-1:0] MS_PER_SEC = 32'd1000;
	localparam logic [FracW-1:0] FRAC_ONE = 11'd1024;
	localparam logic [7:0] ALPHA_FULL = 8'd254;
	localparam logic [7:0] ALPHA_START = 8'd1;
	localparam logic [7:0] ALPHA_NONE = 8'd0;
	localparam logic [7:0] OWNER_RELEASE = 8'd0;
	localparam logic [7:0] OWNER_TAKE = 8'd1;

	localparam logic KIND_OWNER = 1'b0;
	localparam logic KIND_ALPHA = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_FADE_IN,
		OP_FADE_OUT,
		OP_OTHER
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_CLEAR,
		MODE_COVERED,
		MODE_IN,
		MODE_OUT
	} mode_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_DURATION,
		ERR_OVERFLOW,
		ERR_CLOCK
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINISH,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		err_t       err;
		logic       last;
	} result_t;

	function automatic result_t mk_res(input logic kind, input logic [7:0] value,
		input err_t err, input logic last);
		result_t r;
		r.kind = kind;
		r.value = value;
		r.err = err;
		r.last = last;
		return r;
	endfunction

endpackage

[sv/tafc_div.sv]
module tafc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tafc_pkg::DivW-1:0]         dividend,
	input  logic [tafc_pkg::DivisorW-1:0]     divisor,
	output logic                              done,
	output logic [tafc_pkg::DivW-1:0]         quotient
);
	import tafc_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DivCntW-1:0]  cnt_q;
	logic [DivisorW-1:0] rem_q;
	logic [DivisorW-1:0] dsr_q;
	logic [DivW-1:0]     dq_q;
	logic [DivisorW+1:0] trial;
	logic                borrow;

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of the top of dq_q while quotient bits shift in at the bottom.
	assign trial = {1'b0, rem_q, dq_q[DivW-1]} - {2'b00, dsr_q};
	assign borrow = trial[DivisorW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DivCntW'(DivW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dq_q <= dividend;
		end else if (busy_q) begin
			rem_q <= borrow ? {rem_q[DivisorW-2:0], dq_q[DivW-1]} : trial[DivisorW-1:0];
			dq_q <= {dq_q[DivW-2:0], ~borrow};
		end
	end

	assign done = done_q;
	assign quotient = dq_q;

endmodule

[sv/tafc_obuf.sv]
module tafc_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  tafc_pkg::result_t push_data,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,
	output logic              m_axis_tuser,
	output logic              m_axis_tlast
);
	import tafc_pkg::*;

	logic    valid_q;
	result_t data_q;

	// A new beat may enter when the register is empty or drains this cycle.
	assign push_ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ready && push_valid) begin
			data_q <= push_data;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {6'b0, data_q.err, data_q.value};
	assign m_axis_tuser = data_q.kind;
	assign m_axis_tlast = data_q.last;

endmodule

[sv/timed_alpha_fade_controller_core.sv]
// Timed alpha fade controller.
// Input channel (s_axis): one beat per event. tuser carries the opcode (tick,
// fade-in, fade-out, other); tdata carries the duration in milliseconds and the
// current clock in 1/1024 s ticks. Output channel (m_axis): zero, one or two
// result beats per event; tuser says whether tdata is an owner flag or an alpha
// level, tdata also holds the error code, and tlast marks the final beat that
// an event causes.
// Event handling: an instant command, a bad duration, a tick before the fade
// start or after the deadline go from the check state straight to the output
// push; a tick outside a fade or an ignored event ends in the check state with
// no result. A timed command or a tick inside a fade runs the serial divider,
// one quotient bit per cycle, then the finish decode and, when it has results,
// the output push. The block takes one event at a time and accepts no new event
// until the last one has pushed all its results.
// Reset clears the fade mode to clear, and start and deadline to zero.
// Results sit in an output register; when the receiver stalls, the pending beat
// holds there and the controller waits before pushing the next one, so no beat
// is lost or duplicated.
module timed_alpha_fade_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] duration_ms, [63:32] now_ticks
	input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] effect_value, [9:8] error_code, rest zero
	output logic        m_axis_tuser,  // [0] effect_kind
	output logic        m_axis_tlast   // last_of_run
);
	import tafc_pkg::*;

	state_t state_q, state_d;

	// Fade state.
	mode_t       mode_q;
	logic [31:0] start_q;
	logic [31:0] deadline_q;

	// Captured event and the two differences against the fade start.
	opcode_t     op_q;
	logic [31:0] dur_q;
	logic [31:0] now_q;
	logic [33:0] d_now_q;
	logic [33:0] d_span_q;

	// Results waiting to be pushed to the output register.
	result_t pend0_q, pend1_q;
	logic    two_q;

	logic accept;

	// Divider hookup.
	logic                div_start;
	logic [DivW-1:0]     div_dividend;
	logic [DivisorW-1:0] div_divisor;
	logic                div_done;
	logic [DivW-1:0]     div_quot;

	// Output register hookup.
	logic    push_valid;
	logic    push_ready;
	result_t push_data;

	// Decisions taken in the check state.
	logic    chk_div;
	logic    chk_emit;
	logic    chk_two;
	logic    chk_mode_we;
	mode_t   chk_mode;
	result_t chk_res0, chk_res1;
	logic    is_tick;
	logic    fading;
	logic    before_start;
	logic    past_deadline;

	// Decisions taken once the divider has finished.
	logic             fin_emit;
	logic             fin_two;
	logic             fin_commit;
	mode_t            fin_mode;
	result_t          fin_res0, fin_res1;
	logic [32:0]      end_sum;
	logic             ovf;
	logic [FracW-1:0] frac;
	logic [FracW-1:0] frac_adj;
	logic [18:0]      alpha_prod;

	logic load_chk;
	logic load_fin;

	assign accept = s_axis_tvalid && s_axis_tready;

	tafc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	tafc_obuf u_obuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Check-state decode. The differences were formed at accept time, so here
	// only the sign of d_now_q and one compare remain.
	always_comb begin
		is_tick = (op_q == OP_TICK);
		fading = (mode_q == MODE_IN) || (mode_q == MODE_OUT);
		before_start = d_now_q[33];
		past_deadline = $signed(d_now_q) > $signed(d_span_q);
		chk_div = 1'b0;
		chk_emit = 1'b0;
		chk_two = 1'b0;
		chk_mode_we = 1'b0;
		chk_mode = mode_q;
		chk_res0 = mk_res(KIND_OWNER, OWNER_RELEASE, ERR_NONE, 1'b1);
		chk_res1 = mk_res(KIND_ALPHA, ALPHA_FULL, ERR_NONE, 1'b1);
		div_dividend = {1'b0, dur_q[30:0], 10'b0};
		div_divisor = MS_PER_SEC;
		case (op_q)
			OP_TICK: begin
				div_dividend = {d_now_q[31:0], 10'b0};
				div_divisor = d_span_q[31:0];
				if (fading) begin
					if (before_start) begin
						chk_emit = 1'b1;
						chk_res0 = mk_res(KIND_OWNER, 8'd0, ERR_CLOCK, 1'b1);
					end else if (past_deadline) begin
						chk_emit = 1'b1;
						chk_mode_we = 1'b1;
						if (mode_q == MODE_IN) begin
							// Fade-in done: fully clear, then hand control back.
							chk_two = 1'b1;
							chk_res0 = mk_res(KIND_ALPHA, ALPHA_NONE, ERR_NONE, 1'b0);
							chk_res1 = mk_res(KIND_OWNER, OWNER_TAKE, ERR_NONE, 1'b1);
							chk_mode = MODE_CLEAR;
						end else begin
							chk_res0 = mk_res(KIND_ALPHA, ALPHA_FULL, ERR_NONE, 1'b1);
							chk_mode = MODE_COVERED;
						end
					end else begin
						chk_div = 1'b1;
					end
				end
			end
			OP_FADE_IN, OP_FADE_OUT: begin
				if (dur_q == '0) begin
					// Instant command snaps straight to the end state.
					chk_emit = 1'b1;
					chk_mode_we = 1'b1;
					if (op_q == OP_FADE_IN) begin
						chk_res0 = mk_res(KIND_OWNER, OWNER_TAKE, ERR_NONE, 1'b1);
						chk_mode = MODE_CLEAR;
					end else begin
						chk_two = 1'b1;
						chk_res0 = mk_res(KIND_OWNER, OWNER_RELEASE, ERR_NONE, 1'b0);
						chk_res1 = mk_res(KIND_ALPHA, ALPHA_FULL, ERR_NONE, 1'b1);
						chk_mode = MODE_COVERED;
					end
				end else if (dur_q[31]) begin
					chk_emit = 1'b1;
					chk_res0 = mk_res(KIND_OWNER, 8'd0, ERR_DURATION, 1'b1);
				end else begin
					chk_div = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Finish decode: the quotient is either the fade fraction or the duration
	// in ticks.
	always_comb begin
		frac = div_quot[FracW-1:0];
		frac_adj = (mode_q == MODE_IN) ? (FRAC_ONE - frac) : frac;
		alpha_prod = {8'b0, frac_adj} * {11'b0, ALPHA_FULL};
		end_sum = {now_q[31], now_q} + {1'b0, div_quot[31:0]};
		ovf = (|div_quot[DivW-1:31]) || (!end_sum[32] && end_sum[31]);
		fin_emit = 1'b0;
		fin_two = 1'b0;
		fin_commit = 1'b0;
		fin_mode = mode_q;
		fin_res0 = mk_res(KIND_ALPHA, alpha_prod[17:10], ERR_NONE, 1'b1);
		fin_res1 = mk_res(KIND_ALPHA, ALPHA_START, ERR_NONE, 1'b1);
		if (is_tick) begin
			fin_emit = 1'b1;
		end else if (ovf) begin
			fin_emit = 1'b1;
			fin_res0 = mk_res(KIND_OWNER, 8'd0, ERR_OVERFLOW, 1'b1);
		end else begin
			fin_commit = 1'b1;
			if (op_q == OP_FADE_IN) begin
				fin_mode = MODE_IN;
			end else begin
				// Fade-out releases control and shows the first alpha step.
				fin_emit = 1'b1;
				fin_two = 1'b1;
				fin_res0 = mk_res(KIND_OWNER, OWNER_RELEASE, ERR_NONE, 1'b0);
				fin_mode = MODE_OUT;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (chk_div) begin
					state_d = ST_DIV;
				end else if (chk_emit) begin
					state_d = ST_EMIT0;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = fin_emit ? ST_EMIT0 : ST_IDLE;
			end
			ST_EMIT0: begin
				if (push_ready) begin
					state_d = two_q ? ST_EMIT1 : ST_IDLE;
				end
			end
			ST_EMIT1: begin
				if (push_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		div_start = 1'b0;
		push_valid = 1'b0;
		push_data = pend0_q;
		load_chk = 1'b0;
		load_fin = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_CHECK: begin
				div_start = chk_div;
				load_chk = 1'b1;
			end
			ST_FINISH: begin
				load_fin = 1'b1;
			end
			ST_EMIT0: begin
				push_valid = 1'b1;
			end
			ST_EMIT1: begin
				push_valid = 1'b1;
				push_data = pend1_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_CLEAR;
			start_q <= '0;
			deadline_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_chk && chk_mode_we) begin
				mode_q <= chk_mode;
			end
			if (load_fin && fin_commit) begin
				mode_q <= fin_mode;
				start_q <= now_q;
				deadline_q <= end_sum[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode_t'(s_axis_tuser);
			dur_q <= s_axis_tdata[31:0];
			now_q <= s_axis_tdata[63:32];
			d_now_q <= {{2{s_axis_tdata[63]}}, s_axis_tdata[63:32]} -
				{{2{start_q[31]}}, start_q};
			d_span_q <= {{2{deadline_q[31]}}, deadline_q} - {{2{start_q[31]}}, start_q};
		end
		if (load_chk && chk_emit) begin
			pend0_q <= chk_res0;
			pend1_q <= chk_res1;
			two_q <= chk_two;
		end
		if (load_fin && fin_emit) begin
			pend0_q <= fin_res0;
			pend1_q <= fin_res1;
			two_q <= fin_two;
		end
	end

endmodule

[test/tb_timed_alpha_fade_controller_core.sv]
module tb_timed_alpha_fade_controller_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tafc_pkg::*;

	// Clock rate of the fade clock and the millisecond scale of the command argument.
	localparam longint TICKS_PER_SEC = 1024;
	localparam longint MS_IN_SEC = 1000;
	localparam longint S32_MAX = 2147483647;
	localparam longint S32_MIN = -2147483648;
	// The limit leaves ample room for a long receiver stall on top of the slowest
	// event, a divider pass.
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 120;
	localparam int EVENT_TARGET = 1850;

	// Tracks the fade state the block should hold and the effect beats it owes.
	class fade_effect_tracker;
		mode_t fade_state;
		longint start_tick;
		longint deadline_tick;
		result_t effects_due[$];
		int failures;

		function new();
			fade_state = MODE_CLEAR;
			start_tick = 0;
			deadline_tick = 0;
			failures = 0;
		endfunction

		function void push_effect(logic kind, logic [7:0] value, err_t code, logic last);
			result_t r;
			r.kind = kind;
			r.value = value;
			r.err = code;
			r.last = last;
			effects_due.push_back(r);
		endfunction

		function int pending();
			return effects_due.size();
		endfunction

		// Applies one accepted event to the tracked state and queues its effects.
		function void note_event(opcode_t op, logic [31:0] dur_raw, logic [31:0] now_raw);
			longint dur;
			longint now_t;
			longint span;
			longint frac;
			dur = longint'(signed'(dur_raw));
			now_t = longint'(signed'(now_raw));
			if (op == OP_OTHER)
				return;
			if (op == OP_TICK) begin
				if (fade_state != MODE_IN && fade_state != MODE_OUT)
					return;
				if (now_t < start_tick) begin
					push_effect(KIND_OWNER, 8'd0, ERR_CLOCK, 1'b1);
					return;
				end
				if (now_t > deadline_tick) begin
					if (fade_state == MODE_IN) begin
						push_effect(KIND_ALPHA, ALPHA_NONE, ERR_NONE, 1'b0);
						push_effect(KIND_OWNER, OWNER_TAKE, ERR_NONE, 1'b1);
						fade_state = MODE_CLEAR;
					end else begin
						push_effect(KIND_ALPHA, ALPHA_FULL, ERR_NONE, 1'b1);
						fade_state = MODE_COVERED;
					end
					return;
				end
				// A running fade always has its deadline after its start.
				if (deadline_tick <= start_tick)
					frac = TICKS_PER_SEC;
				else
					frac = ((now_t - start_tick) * TICKS_PER_SEC) / (deadline_tick - start_tick);
				if (fade_state == MODE_IN)
					frac = TICKS_PER_SEC - frac;
				push_effect(KIND_ALPHA, 8'((254 * frac) / TICKS_PER_SEC), ERR_NONE, 1'b1);
				return;
			end
			// Fade commands. Rejected commands leave the state alone.
			span = 0;
			if (dur != 0) begin
				if (dur < 0) begin
					push_effect(KIND_OWNER, 8'd0, ERR_DURATION, 1'b1);
					return;
				end
				span = (dur * TICKS_PER_SEC) / MS_IN_SEC;
				if (span <= 0 || span > S32_MAX || now_t + span > S32_MAX) begin
					push_effect(KIND_OWNER, 8'd0, ERR_OVERFLOW, 1'b1);
					return;
				end
			end
			if (op == OP_FADE_IN) begin
				if (dur == 0) begin
					push_effect(KIND_OWNER, OWNER_TAKE, ERR_NONE, 1'b1);
					fade_state = MODE_CLEAR;
				end else begin
					start_tick = now_t;
					deadline_tick = now_t + span;
					fade_state = MODE_IN;
				end
				return;
			end
			push_effect(KIND_OWNER, OWNER_RELEASE, ERR_NONE, 1'b0);
			if (dur == 0) begin
				push_effect(KIND_ALPHA, ALPHA_FULL, ERR_NONE, 1'b1);
				fade_state = MODE_COVERED;
			end else begin
				push_effect(KIND_ALPHA, ALPHA_START, ERR_NONE, 1'b1);
				start_tick = now_t;
				deadline_tick = now_t + span;
				fade_state = MODE_OUT;
			end
		endfunction

		// Compares one accepted output beat against the oldest owed effect.
		function void check_effect(result_t got, logic [5:0] pad);
			result_t want;
			if (effects_due.size() == 0) begin
				$display("%0t: unexpected effect beat kind %0d value %0d err %0d last %0d",
					$time, got.kind, got.value, got.err, got.last);
				failures++;
				return;
			end
			want = effects_due.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t: effect_kind expected %0d, got %0d", $time, want.kind, got.kind);
				failures++;
			end
			if (got.value !== want.value) begin
				$display("%0t: effect_value expected %0d, got %0d", $time, want.value, got.value);
				failures++;
			end
			if (got.err !== want.err) begin
				$display("%0t: error_code expected %0d, got %0d", $time, want.err, got.err);
				failures++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_of_run expected %0d, got %0d", $time, want.last, got.last);
				failures++;
			end
			if (pad !== 6'd0) begin
				$display("%0t: tdata padding expected 0, got %0h", $time, pad);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	fade_effect_tracker tracker = new();

	// Chance in percent that the sender holds back a beat in a given cycle, and
	// that the receiver drops tready in a given cycle.
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int events_sent = 0;
	int idle_cycles = 0;

	timed_alpha_fade_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver changes tready only at the falling edge, so the block sees a
	// settled value at every rising edge.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Every output beat that completes a handshake is checked at the rising edge.
	initial begin
		result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.value = m_axis_tdata[7:0];
				got.err = err_t'(m_axis_tdata[9:8]);
				got.last = m_axis_tlast;
				tracker.check_effect(got, m_axis_tdata[15:10]);
			end
		end
	end

	// The watchdog counts cycles in which no beat moves on either side. The
	// divider and the receiver's stalls both leave such cycles, but never
	// anywhere near this many in a row.
	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timed_alpha_fade_controller_core regression: fail");
		$finish;
	end

	// Sends one event beat. It is called at a falling edge and returns at the
	// falling edge after the beat was taken, leaving tvalid high so that
	// back-to-back beats need no gap.
	task automatic send_event(input opcode_t op, input logic [31:0] dur,
		input logic [31:0] now_t);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {now_t, dur};
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.note_event(op, dur, now_t);
		if (op != OP_OTHER)
			events_sent++;
		@(negedge clk);
	endtask

	// Holds the sender off until every owed effect beat has arrived.
	task automatic drain_effects();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	// A stray beat: an ignored event, a tick from before the start, a random tick
	// (which can end a fade in progress) or a command with a negative
	// duration.
	task automatic send_noise(input longint base);
		case ($urandom_range(3))
			0: send_event(OP_OTHER, $urandom, $urandom);
			1: send_event(OP_TICK, $urandom, 32'(base - $urandom_range(1, 1000)));
			2: send_event(OP_TICK, $urandom, $urandom);
			default: send_event($urandom_range(1) ? OP_FADE_IN : OP_FADE_OUT,
				$urandom | 32'h8000_0000, $urandom);
		endcase
	endtask

	// One fade command followed by ticks that walk from the start through the
	// deadline and past it, with the odd stray beat mixed in.
	task automatic fade_sequence();
		longint base;
		longint span;
		logic [31:0] dur;
		opcode_t cmd;
		int n_ticks;
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			base = longint'(signed'(32'($urandom)));
		else if (pick < 85)
			base = S32_MIN + $urandom_range(0, 5000);
		else
			base = S32_MAX - $urandom_range(0, 200000);
		pick = $urandom_range(99);
		if (pick < 75)
			dur = $urandom_range(1, 3000);
		else if (pick < 85)
			dur = $urandom_range(1, 2097151999);
		else if (pick < 92)
			dur = 32'd0;
		else if (pick < 96)
			dur = $urandom | 32'h8000_0000;
		else
			dur = $urandom_range(2097152000, 32'h7FFF_FFFF);
		cmd = $urandom_range(1) ? OP_FADE_IN : OP_FADE_OUT;
		send_event(cmd, dur, 32'(base));
		span = (longint'(dur) * TICKS_PER_SEC) / MS_IN_SEC;
		n_ticks = $urandom_range(1, 10);
		for (int i = 0; i <= n_ticks; i++) begin
			if ($urandom_range(9) == 0)
				send_noise(base);
			send_event(OP_TICK, $urandom, 32'(base + (span * i) / n_ticks));
		end
		send_event(OP_TICK, $urandom, 32'(base + span + 1 + $urandom_range(0, 100)));
	endtask

	initial begin
		int seq_count;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_TICK;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. After reset the fade is clear, so a tick does nothing
		// and an ignored event with every field at an extreme does nothing either.
		send_event(OP_TICK, 32'd0, 32'd0);
		send_event(OP_OTHER, 32'hFFFF_FFFF, 32'h8000_0000);
		// Instant fade-out covers at once; a tick while covered is silent.
		send_event(OP_FADE_OUT, 32'd0, 32'h7FFF_FFFF);
		send_event(OP_TICK, 32'd5, 32'd100);
		// Instant fade-in hands control back.
		send_event(OP_FADE_IN, 32'd0, 32'h8000_0000);
		// Negative durations and the two overflow cases are rejected.
		send_event(OP_FADE_IN, 32'h8000_0000, 32'd0);
		send_event(OP_FADE_OUT, 32'hFFFF_FFFF, 32'd0);
		send_event(OP_FADE_IN, 32'h7FFF_FFFF, 32'd0);
		send_event(OP_FADE_OUT, 32'd1000, 32'h7FFF_FFFF);
		// A one-second fade-in: a tick before the start is an error, then the
		// alpha falls from full to none, holds at the deadline and ends past it.
		send_event(OP_FADE_IN, 32'd1000, 32'd0);
		send_event(OP_TICK, 32'd0, 32'hFFFF_FFFF);
		send_event(OP_TICK, 32'd0, 32'd0);
		send_event(OP_TICK, 32'd0, 32'd512);
		send_event(OP_TICK, 32'd0, 32'd1024);
		send_event(OP_TICK, 32'd0, 32'd1025);
		// A short fade-out starting at the most negative clock.
		send_event(OP_FADE_OUT, 32'd100, 32'h8000_0000);
		send_event(OP_TICK, 32'd0, 32'h8000_0033);
		send_event(OP_TICK, 32'd0, 32'h7FFF_FFFF);
		// The longest fade whose deadline still fits: the clock at the deadline
		// keeps it running at full alpha, and a tick at the start gives none.
		send_event(OP_FADE_OUT, 32'd2097151999, 32'd1);
		send_event(OP_TICK, 32'd0, 32'h7FFF_FFFF);
		send_event(OP_TICK, 32'd0, 32'd1);
		send_event(OP_TICK, 32'd0, 32'd0);
		drain_effects();

		// Random part, cycling through the idling phases.
		seq_count = 0;
		while (events_sent < EVENT_TARGET) begin
			case ((seq_count / 12) % 5)
				0: begin src_idle_pct = 0; sink_stall_pct = 0; end
				1: begin src_idle_pct = 57; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 57; end
				3: begin src_idle_pct = 21; sink_stall_pct = 21; end
				default: begin src_idle_pct = 0; sink_stall_pct = 0; end
			endcase
			if (seq_count % 50 == 25)
				drain_effects();
			fade_sequence();
			seq_count++;
		end

		drain_effects();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("timed_alpha_fade_controller_core regression: pass");
		else
			$display("timed_alpha_fade_controller_core regression: fail");
		$finish;
	end

endmodule
